// File: rtl/pog_pkg.sv
package pog_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   // count must also hold the scan index one past the end
   localparam int CNT_W     = $clog2(MAX_ITEMS + 2);
   localparam int ARR_W     = 6;
   localparam int SHEET_W   = 8;
   localparam int COORD_W   = 31;

   localparam logic [COORD_W-1:0] KEY_TOP = 31'h7FFF_FFFF;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // packed so that a plain unsigned compare gives sheet, primary, secondary order
   typedef struct packed {
      logic [SHEET_W-1:0] sheet;
      logic [COORD_W-1:0] primary;
      logic [COORD_W-1:0] secondary;
   } key_type;

   typedef struct packed {
      logic    key_we;
      idx_type key_waddr;
      logic    ord_we;
      idx_type ord_waddr;
      idx_type ord_wdata;
      idx_type ord_raddr_a;
      idx_type ord_raddr_b;
   } ram_ctl_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_CHECK,
      ST_RD_ORD,
      ST_RD_KEY,
      ST_CMP,
      ST_SWAP_LO,
      ST_SWAP_HI,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_WAIT
   } state_type;

endpackage

// File: rtl/pog_if.sv
interface pog_req_if;
   import pog_pkg::*;

   logic               valid;
   logic               ready;
   logic [SHEET_W-1:0] sheet_number;
   logic [COORD_W-1:0] x_position;
   logic [COORD_W-1:0] y_position;
   logic               last_item;

   modport source (output valid, sheet_number, x_position, y_position, last_item,
                   input ready);
   modport sink   (input valid, sheet_number, x_position, y_position, last_item,
                   output ready);
endinterface

interface pog_rsp_if;
   import pog_pkg::*;

   logic             valid;
   logic             ready;
   logic [ARR_W-1:0] arrival_position;
   logic             overflow;
   logic             last_result;

   modport source (output valid, arrival_position, overflow, last_result,
                   input ready);
   modport sink   (input valid, arrival_position, overflow, last_result,
                   output ready);
endinterface

// File: rtl/placement_order_gnome_sort.sv
// Load: one item per cycle, ready is high while the block is collecting a set.
// After the item marked last, the order list is seeded with 0..n-1; the gnome
// sort uses one shared key comparator: a compare steps CHECK, RD_ORD, RD_KEY,
// CMP, a swap adds SWAP_LO, SWAP_HI; up to n-1 forward compares, n*(n-1)/2 swaps.
// Results step EMIT_RD, EMIT_LD, EMIT_WAIT, held on stall; ready returns after the last.
// Sync active-high reset clears count, overflow and state; no clearing pass.
module placement_order_gnome_sort (
   input  logic      clock,
   input  logic      reset,
   pog_req_if.sink   req_ch,
   pog_rsp_if.source rsp_ch,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);
   import pog_pkg::*;

   logic        scan_dir_ff, scan_dir_in;
   key_type     load_key;
   key_type     key_a;
   key_type     key_b;
   idx_type     ord_rdata_a;
   idx_type     ord_rdata_b;
   logic        precedes;
   ram_ctl_type ram_ctl;
   logic [COORD_W-1:0] flipped_y;

   assign scan_dir_in = csr_wr_en ? csr_wr_data : scan_dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_dir_ff <= 1'b0;
      end else begin
         scan_dir_ff <= scan_dir_in;
      end
   end

   assign flipped_y = KEY_TOP - req_ch.y_position;

   always_comb begin
      load_key.sheet = req_ch.sheet_number;
      if (scan_dir_ff) begin
         load_key.primary   = flipped_y;
         load_key.secondary = req_ch.x_position;
      end else begin
         load_key.primary   = req_ch.x_position;
         load_key.secondary = flipped_y;
      end
   end

   pog_ram #(
      .WIDTH ($bits(key_type)),
      .DEPTH (MAX_ITEMS)
   ) u_key_ram (
      .clock   (clock),
      .we      (ram_ctl.key_we),
      .waddr   (ram_ctl.key_waddr),
      .wdata   (load_key),
      .raddr_a (ord_rdata_a),
      .raddr_b (ord_rdata_b),
      .rdata_a (key_a),
      .rdata_b (key_b)
   );

   pog_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_ITEMS)
   ) u_ord_ram (
      .clock   (clock),
      .we      (ram_ctl.ord_we),
      .waddr   (ram_ctl.ord_waddr),
      .wdata   (ram_ctl.ord_wdata),
      .raddr_a (ram_ctl.ord_raddr_a),
      .raddr_b (ram_ctl.ord_raddr_b),
      .rdata_a (ord_rdata_a),
      .rdata_b (ord_rdata_b)
   );

   pog_key_cmp u_cmp (
      .key_a    (key_a),
      .key_b    (key_b),
      .precedes (precedes)
   );

   pog_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .ord_rdata_a (ord_rdata_a),
      .ord_rdata_b (ord_rdata_b),
      .precedes    (precedes),
      .ram_ctl     (ram_ctl)
   );

endmodule

// File: rtl/pog_ram.sv
module pog_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

// File: rtl/pog_key_cmp.sv
module pog_key_cmp (
   input  pog_pkg::key_type key_a,
   input  pog_pkg::key_type key_b,
   output logic             precedes
);
   import pog_pkg::*;

   // strict less-than over sheet, primary, secondary; ties do not precede
   assign precedes = (key_a < key_b);

endmodule

// File: rtl/pog_seq.sv
module pog_seq (
   input  logic                 clock,
   input  logic                 reset,
   pog_req_if.sink              req,
   pog_rsp_if.source            rsp,
   input  pog_pkg::idx_type     ord_rdata_a,
   input  pog_pkg::idx_type     ord_rdata_b,
   input  logic                 precedes,
   output pog_pkg::ram_ctl_type ram_ctl
);
   import pog_pkg::*;

   state_type state_ff, state_in;
   cnt_type   cnt_ff, cnt_in;
   logic      ovf_ff, ovf_in;
   cnt_type   i_ff, i_in;
   cnt_type   j_ff, j_in;
   cnt_type   k_ff, k_in;
   idx_type   a_ff, a_in;
   idx_type   b_ff, b_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [ARR_W-1:0] arr_ff, arr_in;
   logic      last_ff, last_in;

   logic    req_fire;
   logic    has_room;
   cnt_type k_inc;
   cnt_type i_dec;
   cnt_type j_inc;

   assign req_fire = req.valid && req.ready;
   assign has_room = (cnt_ff < CNT_W'(MAX_ITEMS));
   assign k_inc    = k_ff + 1'b1;
   assign i_dec    = i_ff - 1'b1;
   assign j_inc    = j_ff + 1'b1;

   assign req.ready            = (state_ff == ST_LOAD);
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.arrival_position = arr_ff;
   assign rsp.overflow         = ovf_ff;
   assign rsp.last_result      = last_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire && req.last_item) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            if (k_inc == cnt_ff) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (i_ff < cnt_ff) ? ST_RD_ORD : ST_EMIT_RD;
         end
         ST_RD_ORD:  state_in = ST_RD_KEY;
         ST_RD_KEY:  state_in = ST_CMP;
         ST_CMP:     state_in = precedes ? ST_CHECK : ST_SWAP_LO;
         ST_SWAP_LO: state_in = ST_SWAP_HI;
         ST_SWAP_HI: state_in = ST_CHECK;
         ST_EMIT_RD: state_in = ST_EMIT_LD;
         ST_EMIT_LD: state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: begin
            if (rsp.ready) begin
               state_in = last_ff ? ST_LOAD : ST_EMIT_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rsp_valid_in = rsp_valid_ff;
      arr_in       = arr_ff;
      last_in      = last_ff;

      ram_ctl             = '0;
      ram_ctl.key_waddr   = cnt_ff[IDX_W-1:0];
      ram_ctl.ord_raddr_a = i_dec[IDX_W-1:0];
      ram_ctl.ord_raddr_b = i_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_LOAD: begin
            k_in = '0;
            if (req_fire) begin
               if (has_room) begin
                  ram_ctl.key_we = 1'b1;
                  cnt_in         = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_INIT: begin
            ram_ctl.ord_we    = 1'b1;
            ram_ctl.ord_waddr = k_ff[IDX_W-1:0];
            ram_ctl.ord_wdata = k_ff[IDX_W-1:0];
            k_in              = k_inc;
            i_in              = CNT_W'(1);
            j_in              = CNT_W'(2);
         end
         ST_CHECK: begin
            k_in = '0;
         end
         ST_RD_ORD: begin
         end
         ST_RD_KEY: begin
            a_in = ord_rdata_a;
            b_in = ord_rdata_b;
         end
         ST_CMP: begin
            if (precedes) begin
               i_in = j_ff;
               j_in = j_inc;
            end
         end
         ST_SWAP_LO: begin
            ram_ctl.ord_we    = 1'b1;
            ram_ctl.ord_waddr = i_dec[IDX_W-1:0];
            ram_ctl.ord_wdata = b_ff;
         end
         ST_SWAP_HI: begin
            ram_ctl.ord_we    = 1'b1;
            ram_ctl.ord_waddr = i_ff[IDX_W-1:0];
            ram_ctl.ord_wdata = a_ff;
            // step back; at the front, jump ahead to the saved position
            if (i_dec == '0) begin
               i_in = j_ff;
               j_in = j_inc;
            end else begin
               i_in = i_dec;
            end
         end
         ST_EMIT_RD: begin
            ram_ctl.ord_raddr_a = k_ff[IDX_W-1:0];
         end
         ST_EMIT_LD: begin
            ram_ctl.ord_raddr_a = k_ff[IDX_W-1:0];
            arr_in       = ARR_W'(ord_rdata_a);
            last_in      = (k_inc == cnt_ff);
            rsp_valid_in = 1'b1;
         end
         ST_EMIT_WAIT: begin
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               k_in         = k_inc;
               if (last_ff) begin
                  cnt_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      arr_ff  <= arr_in;
      last_ff <= last_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count beyond capacity");

   a_valid_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_EMIT_WAIT))
      else $error("result shown outside the emit wait state");

   a_sort_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> ((i_ff != '0) && (i_ff < j_ff)))
      else $error("sort index out of order");

   a_swap_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWAP_LO) |=> (state_ff == ST_SWAP_HI) && $stable(i_ff))
      else $error("swap not completed on the same pair");

endmodule
